// ----- rtl/ftp_reply_login_sequencer_core_assert.svh -----
`ifndef FTP_REPLY_LOGIN_SEQUENCER_CORE_ASSERT_SVH
`define FTP_REPLY_LOGIN_SEQUENCER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define FRLS_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define FRLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/frls_pkg.sv -----
package frls_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned ActionW = 3;
  localparam int unsigned FieldW  = 3;

  typedef enum logic {
    OP_RX_BYTE   = 1'b0,
    OP_ARM_PASV  = 1'b1
  } opcode_e;

  typedef enum logic [ActionW-1:0] {
    ACT_REPORT     = 3'd0,
    ACT_SEND_USER  = 3'd1,
    ACT_SEND_PASS  = 3'd2,
    ACT_LOGGED_IN  = 3'd3,
    ACT_PASV_READY = 3'd4,
    ACT_LOGIN_FAIL = 3'd5,
    ACT_NO_CREDS   = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    STG_GREETING  = 2'd0,
    STG_USER_SENT = 2'd1,
    STG_PASS_SENT = 2'd2,
    STG_LOGGED_IN = 2'd3
  } stage_e;

  localparam logic [CodeW-1:0] CodeGreeting = 16'd220;
  localparam logic [CodeW-1:0] CodeNeedPass = 16'd331;
  localparam logic [CodeW-1:0] CodeLoggedIn = 16'd230;
  localparam logic [CodeW-1:0] CodePassive  = 16'd227;

  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChDash   = 8'h2d;
  localparam logic [ByteW-1:0] ChCr     = 8'h0d;
  localparam logic [ByteW-1:0] ChLf     = 8'h0a;
  localparam logic [ByteW-1:0] ChOpen   = 8'h28;
  localparam logic [ByteW-1:0] ChClose  = 8'h29;
  localparam logic [ByteW-1:0] ChComma  = 8'h2c;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [FieldW-1:0] AddrFields = 3'd4;
  localparam logic [FieldW-1:0] FieldMax   = 3'd7;

  // value*10 + digit, wrapping at 16 bits
  function automatic logic [CodeW-1:0] fold_digit(logic [CodeW-1:0] value,
                                                  logic [ByteW-1:0] ch);
    logic [CodeW-1:0] times_ten;
    times_ten  = (value << 3) + (value << 1);
    fold_digit = times_ten + {{(CodeW-ByteW){1'b0}}, ch} - {{(CodeW-ByteW){1'b0}}, ChZero};
  endfunction

endpackage

// ----- rtl/frls_in_if.sv -----
interface frls_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [frls_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- rtl/frls_out_if.sv -----
interface frls_out_if;
  logic                         valid;
  logic                         ready;
  logic [frls_pkg::ActionW-1:0] action;
  logic [frls_pkg::CodeW-1:0]   reply_code;
  logic [frls_pkg::AddrW-1:0]   server_addr;
  logic [frls_pkg::PortW-1:0]   server_port;

  modport source (output valid, output action, output reply_code, output server_addr,
                  output server_port, input ready);
  modport sink   (input valid, input action, input reply_code, input server_addr,
                  input server_port, output ready);
endinterface

// ----- rtl/ftp_reply_login_sequencer_core.sv -----
// FTP control reply sequencer with login steps and passive address parsing.
// in_i carries one item per transfer: opcode 0 with a reply byte, or opcode 1
// to arm passive handling of the next 227 reply. out_o carries at most one
// result per input item: action, reply code, passive address and port.
// cfg_wr_en_i / cfg_wr_data_i write the credentials-present flag; write it
// only while the block is idle.
// An item accepted into the input stage is processed when that stage fires; any
// result it yields is captured in the result register and shows on out_o.
// Throughput: one item per cycle while out_o is not stalled, set by the single
// processing register stage feeding the result register.
// When out_o is stalled, the held result blocks the processing stage, which
// then holds its item and drops in_i.ready; with the result register free,
// an item enters every cycle.
// Reset clears the parser, sets the login stage to awaiting greeting, arms
// passive handling, clears the halt flag and credentials, and empties both
// stages.
module ftp_reply_login_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic       cfg_wr_data_i,
  frls_in_if.sink    in_i,
  frls_out_if.source out_o
);
  import frls_pkg::*;

  `include "ftp_reply_login_sequencer_core_assert.svh"

  // input stage
  logic             s1_valid_q;
  logic             s1_opcode_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_fire;

  // result register
  logic              out_valid_q;
  logic [ActionW-1:0] out_action_q,  out_action_d;
  logic [CodeW-1:0]   out_code_q,    out_code_d;
  logic [AddrW-1:0]   out_addr_q,    out_addr_d;
  logic [PortW-1:0]   out_port_q,    out_port_d;
  logic               result_d;

  // state
  logic              cred_q;
  logic              halted_q,      halted_d;
  stage_e            stage_q,       stage_d;
  logic              armed_q,       armed_d;
  logic              code_done_q,   code_done_d;
  logic              cont_q,        cont_d;
  logic [CodeW-1:0]  code_q,        code_d;
  logic              in_parens_q,   in_parens_d;
  logic              closed_q,      closed_d;
  logic [FieldW-1:0] field_q,       field_d;
  logic [CodeW-1:0]  num_q,         num_d;
  logic [AddrW-1:0]  addr_q,        addr_d;
  logic [PortW-1:0]  port_q,        port_d;

  logic line_end;
  logic no_creds;
  logic is_digit;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  assign is_digit = (s1_byte_q >= ChZero) && (s1_byte_q <= ChNine);

  // byte parser
  always_comb begin
    armed_d     = armed_q;
    code_done_d = code_done_q;
    cont_d      = cont_q;
    code_d      = code_q;
    in_parens_d = in_parens_q;
    closed_d    = closed_q;
    field_d     = field_q;
    num_d       = num_q;
    addr_d      = addr_q;
    port_d      = port_q;
    line_end    = 1'b0;
    no_creds    = 1'b0;
    if (s1_opcode_q == OP_ARM_PASV) begin
      armed_d = 1'b1;
    end else if (halted_q) begin
      armed_d = armed_q;
    end else if (!cred_q) begin
      no_creds = 1'b1;
    end else if (!code_done_q) begin
      if (s1_byte_q == ChSpace || s1_byte_q == ChDash) begin
        cont_d      = (s1_byte_q == ChDash);
        code_done_d = 1'b1;
      end else begin
        code_d = fold_digit(code_q, s1_byte_q);
      end
    end else if (s1_byte_q == ChLf) begin
      code_done_d = 1'b0;
      code_d      = '0;
      if (!cont_q) begin
        line_end    = 1'b1;
        if (stage_q == STG_LOGGED_IN && code_q == CodePassive && armed_q) begin
          armed_d = 1'b0;
        end
        in_parens_d = 1'b0;
        closed_d    = 1'b0;
        field_d     = '0;
        num_d       = '0;
        addr_d      = '0;
        port_d      = '0;
      end
    end else if (s1_byte_q != ChCr && !closed_q) begin
      if (s1_byte_q == ChOpen) begin
        in_parens_d = 1'b1;
      end else if (in_parens_q) begin
        if (s1_byte_q == ChComma || s1_byte_q == ChClose) begin
          if (field_q < AddrFields) begin
            addr_d = {addr_q[AddrW-ByteW-1:0], num_q[ByteW-1:0]};
          end else begin
            port_d = {port_q[PortW-ByteW-1:0], {ByteW{1'b0}}} | num_q;
          end
          num_d = '0;
          if (field_q < FieldMax) begin
            field_d = field_q + 1'b1;
          end
          if (s1_byte_q == ChClose) begin
            closed_d = 1'b1;
          end
        end else if (is_digit) begin
          num_d = fold_digit(num_q, s1_byte_q);
        end
      end
    end
  end

  // login stage next state
  always_comb begin
    stage_d  = stage_q;
    halted_d = halted_q;
    if (line_end) begin
      unique case (stage_q)
        STG_GREETING: begin
          if (code_q == CodeGreeting) stage_d = STG_USER_SENT;
          else halted_d = 1'b1;
        end
        STG_USER_SENT: begin
          if (code_q == CodeNeedPass) stage_d = STG_PASS_SENT;
          else halted_d = 1'b1;
        end
        STG_PASS_SENT: begin
          if (code_q == CodeLoggedIn) stage_d = STG_LOGGED_IN;
          else halted_d = 1'b1;
        end
        STG_LOGGED_IN: stage_d = STG_LOGGED_IN;
        default:       stage_d = STG_GREETING;
      endcase
    end
  end

  // result
  always_comb begin
    result_d     = line_end || no_creds;
    out_action_d = ACT_REPORT;
    out_code_d   = code_q;
    out_addr_d   = '0;
    out_port_d   = '0;
    if (no_creds) begin
      out_action_d = ACT_NO_CREDS;
      out_code_d   = '0;
    end else begin
      unique case (stage_q)
        STG_GREETING:
          out_action_d = (code_q == CodeGreeting) ? ACT_SEND_USER : ACT_LOGIN_FAIL;
        STG_USER_SENT:
          out_action_d = (code_q == CodeNeedPass) ? ACT_SEND_PASS : ACT_LOGIN_FAIL;
        STG_PASS_SENT:
          out_action_d = (code_q == CodeLoggedIn) ? ACT_LOGGED_IN : ACT_LOGIN_FAIL;
        STG_LOGGED_IN: begin
          if (code_q == CodePassive && armed_q) begin
            out_action_d = ACT_PASV_READY;
            out_addr_d   = addr_q;
            out_port_d   = port_q;
          end
        end
        default: out_action_d = ACT_REPORT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cred_q      <= 1'b0;
      halted_q    <= 1'b0;
      stage_q     <= STG_GREETING;
      armed_q     <= 1'b1;
      code_done_q <= 1'b0;
      cont_q      <= 1'b0;
      code_q      <= '0;
      in_parens_q <= 1'b0;
      closed_q    <= 1'b0;
      field_q     <= '0;
      num_q       <= '0;
      addr_q      <= '0;
      port_q      <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        cred_q <= cfg_wr_data_i;
      end
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= result_d;
        halted_q    <= halted_d;
        stage_q     <= stage_d;
        armed_q     <= armed_d;
        code_done_q <= code_done_d;
        cont_q      <= cont_d;
        code_q      <= code_d;
        in_parens_q <= in_parens_d;
        closed_q    <= closed_d;
        field_q     <= field_d;
        num_q       <= num_d;
        addr_q      <= addr_d;
        port_q      <= port_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_opcode_q <= in_i.opcode;
      s1_byte_q   <= in_i.rx_byte;
    end
    if (s1_fire && result_d) begin
      out_action_q <= out_action_d;
      out_code_q   <= out_code_d;
      out_addr_q   <= out_addr_d;
      out_port_q   <= out_port_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.action      = out_action_q;
  assign out_o.reply_code  = out_code_q;
  assign out_o.server_addr = out_addr_q;
  assign out_o.server_port = out_port_q;

  `FRLS_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halt flag cleared")
  `FRLS_ASSERT_HOLD(a_halt_stage, !halted_q || stage_q != STG_LOGGED_IN,
                    "halted after login completed")
  `FRLS_ASSERT_HOLD(a_closed_in_parens, !closed_q || in_parens_q,
                    "paren parser closed without opening")
  `FRLS_ASSERT_HOLD(a_pasv_fields,
                    !out_valid_q || out_action_q == ACT_PASV_READY ||
                    (out_addr_q == '0 && out_port_q == '0),
                    "address or port set on non-passive result")

endmodule
